// File: design/bpts_pkg.sv
`default_nettype none

package bpts_pkg;

  localparam int unsigned NUM_SW = 4;

  localparam logic [1:0] POS_OPEN   = 2'd0;
  localparam logic [1:0] POS_CLOSED = 2'd1;
  localparam logic [1:0] POS_FAULT  = 2'd2;

  localparam logic [2:0] TOPO_SPLIT1 = 3'd0;
  localparam logic [2:0] TOPO_SPLIT2 = 3'd1;
  localparam logic [2:0] TOPO_PAR    = 3'd2;
  localparam logic [2:0] TOPO_MAINT  = 3'd3;
  localparam logic [2:0] TOPO_ERR    = 3'd4;

  localparam logic [1:0] FK_OTHER   = 2'd0;
  localparam logic [1:0] FK_FEEDER1 = 2'd1;
  localparam logic [1:0] FK_FEEDER2 = 2'd2;
  localparam logic [1:0] FK_BUS     = 2'd3;

  localparam logic [1:0] BRK_LOCKOUT = 2'd0;
  localparam logic [1:0] BRK_TRIP1   = 2'd1;
  localparam logic [1:0] BRK_TRIP3   = 2'd2;

  localparam logic [1:0] MK_NONE    = 2'd0;
  localparam logic [1:0] MK_CLOSE1  = 2'd1;
  localparam logic [1:0] MK_CLOSE24 = 2'd2;
  localparam logic [1:0] MK_CLOSE3  = 2'd3;

  typedef logic [NUM_SW-1:0][1:0] pos_vec_t;

  typedef struct packed {
    logic [3:0] contact_on_bits;
    logic [3:0] contact_off_bits;
    logic       bus1_live;
    logic       bus2_live;
    logic [1:0] fault_kind;
  } in_word_t;

  typedef struct packed {
    logic [2:0] topology_code;
    logic [1:0] break_step;
    logic [1:0] make_step;
    logic       sync_needed;
  } strat_t;

  typedef struct packed {
    logic [1:0] pos_sw1;
    logic [1:0] pos_sw2;
    logic [1:0] pos_sw3;
    logic [1:0] pos_sw4;
    logic [2:0] topology_code;
    logic [1:0] break_step;
    logic [1:0] make_step;
    logic       sync_needed;
  } out_word_t;

endpackage

`default_nettype wire

// File: design/breaker_position_topology_strategy.sv
// An accepted sample word passes through the input register, then the result
// register, one word per cycle sustained while result_ready stays high.
// The debounce history is updated once per word, as it enters the result register.
// Reset (rst, synchronous): both stages empty, history set to fault, debounced
// positions set to open.
`default_nettype none

module breaker_position_topology_strategy (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  sample_valid,
  output logic                 sample_ready,
  input  bpts_pkg::in_word_t   sample,
  output logic                 result_valid,
  input  wire                  result_ready,
  output bpts_pkg::out_word_t  result
);
  import bpts_pkg::*;

  // Input stage
  logic     stage_valid;
  in_word_t stage;
  logic     advance;

  // Decode pass outputs
  pos_vec_t pos_next;
  strat_t   strat;

  // Move the staged word into the result register whenever the result slot
  // is free or being drained this cycle.
  assign advance      = stage_valid && (!result_valid || result_ready);
  assign sample_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      stage <= sample;
    end
  end

  // Debounce history advances exactly once per word, in arrival order.
  bpts_debounce u_debounce (
    .clk              (clk),
    .rst              (rst),
    .update           (advance),
    .contact_on_bits  (stage.contact_on_bits),
    .contact_off_bits (stage.contact_off_bits),
    .pos_next         (pos_next)
  );

  bpts_strategy u_strategy (
    .both_live  (stage.bus1_live && stage.bus2_live),
    .fault_kind (stage.fault_kind),
    .pos        (pos_next),
    .strat      (strat)
  );

  // Result register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.pos_sw1       <= pos_next[0];
      result.pos_sw2       <= pos_next[1];
      result.pos_sw3       <= pos_next[2];
      result.pos_sw4       <= pos_next[3];
      result.topology_code <= strat.topology_code;
      result.break_step    <= strat.break_step;
      result.make_step     <= strat.make_step;
      result.sync_needed   <= strat.sync_needed;
    end
  end

  // A staged word that cannot advance must still be there next cycle.
  a_stage_kept: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid)
    else $error("staged word lost while stalled");

  // A sync request always goes with a make action.
  a_sync_make: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.sync_needed == (result.make_step != MK_NONE)))
    else $error("sync flag and make action disagree");

  // Only parallel and split topologies carry a trip.
  a_lockout: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.topology_code == TOPO_MAINT ||
                     result.topology_code == TOPO_ERR)
    |-> (result.break_step == BRK_LOCKOUT))
    else $error("trip issued outside a live topology");

  // A faulted switch forces the error topology.
  a_fault_err: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.pos_sw1 == POS_FAULT || result.pos_sw2 == POS_FAULT ||
                     result.pos_sw3 == POS_FAULT || result.pos_sw4 == POS_FAULT)
    |-> (result.topology_code == TOPO_ERR))
    else $error("faulted switch without error topology");

endmodule

`default_nettype wire

// File: design/bpts_debounce.sv
`default_nettype none

module bpts_debounce (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   update,
  input  wire  [3:0]            contact_on_bits,
  input  wire  [3:0]            contact_off_bits,
  output bpts_pkg::pos_vec_t    pos_next
);
  import bpts_pkg::*;

  pos_vec_t prev_raw;
  pos_vec_t debounced;
  pos_vec_t raw;

  // Decode each contact pair, take the raw value once it repeats.
  always_comb begin
    for (int i = 0; i < NUM_SW; i++) begin
      if (contact_on_bits[i] && !contact_off_bits[i]) begin
        raw[i] = POS_CLOSED;
      end else if (!contact_on_bits[i] && contact_off_bits[i]) begin
        raw[i] = POS_OPEN;
      end else begin
        raw[i] = POS_FAULT;
      end
      pos_next[i] = (raw[i] == prev_raw[i]) ? raw[i] : debounced[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SW; i++) begin
        prev_raw[i]  <= POS_FAULT;
        debounced[i] <= POS_OPEN;
      end
    end else if (update) begin
      prev_raw  <= raw;
      debounced <= pos_next;
    end
  end

endmodule

`default_nettype wire

// File: design/bpts_strategy.sv
`default_nettype none

module bpts_strategy (
  input  wire                   both_live,
  input  wire  [1:0]            fault_kind,
  input  bpts_pkg::pos_vec_t    pos,
  output bpts_pkg::strat_t      strat
);
  import bpts_pkg::*;

  logic any_fault;

  always_comb begin
    any_fault = 1'b0;
    for (int i = 0; i < NUM_SW; i++) begin
      any_fault = any_fault | (pos[i] == POS_FAULT);
    end

    // pos[0] is switch 1
    if (any_fault || (pos[1] != pos[3])) begin
      strat.topology_code = TOPO_ERR;
    end else if (pos == {POS_CLOSED, POS_OPEN, POS_CLOSED, POS_CLOSED}) begin
      strat.topology_code = both_live ? TOPO_SPLIT1 : TOPO_ERR;
    end else if (pos == {POS_CLOSED, POS_CLOSED, POS_CLOSED, POS_OPEN}) begin
      strat.topology_code = both_live ? TOPO_SPLIT2 : TOPO_ERR;
    end else if (pos == {POS_OPEN, POS_CLOSED, POS_OPEN, POS_CLOSED}) begin
      strat.topology_code = both_live ? TOPO_PAR : TOPO_ERR;
    end else if (pos == {POS_OPEN, POS_OPEN, POS_OPEN, POS_OPEN}) begin
      strat.topology_code = TOPO_MAINT;
    end else begin
      strat.topology_code = TOPO_ERR;
    end

    strat.break_step  = BRK_LOCKOUT;
    strat.make_step   = MK_NONE;
    strat.sync_needed = 1'b0;
    case (strat.topology_code)
      TOPO_PAR: begin
        if (fault_kind == FK_FEEDER1) begin
          strat.break_step  = BRK_TRIP1;
          strat.make_step   = MK_CLOSE24;
          strat.sync_needed = 1'b1;
        end else if (fault_kind == FK_FEEDER2) begin
          strat.break_step  = BRK_TRIP3;
          strat.make_step   = MK_CLOSE24;
          strat.sync_needed = 1'b1;
        end
      end
      TOPO_SPLIT1: begin
        if (fault_kind == FK_FEEDER1) begin
          strat.break_step  = BRK_TRIP1;
          strat.make_step   = MK_CLOSE3;
          strat.sync_needed = 1'b1;
        end
      end
      TOPO_SPLIT2: begin
        if (fault_kind == FK_FEEDER2) begin
          strat.break_step  = BRK_TRIP3;
          strat.make_step   = MK_CLOSE1;
          strat.sync_needed = 1'b1;
        end
      end
      default: begin
        // bus, other and unmatched faults lock out all
      end
    endcase
  end

endmodule

`default_nettype wire

// File: tb/tb_breaker_position_topology_strategy.sv
`timescale 1ns / 1ps

module tb_breaker_position_topology_strategy;
  import bpts_pkg::*;

  // Run length guard: worst case is every word waiting out a full sender gap
  // plus a full receiver stall plus the two-stage pipe, taken many times over.
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_SHOWN    = 10;

  // Contact patterns of the four legal line-ups, switch 1 in bit 0:
  // split from source 1, split from source 2, parallel, all open.
  localparam logic [15:0] LINEUP_ON = {4'b0000, 4'b0101, 4'b1110, 4'b1011};

  typedef struct {
    in_word_t    w;
    int unsigned gap;
  } sample_job_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      sample_valid = 1'b0;
  logic      sample_ready;
  in_word_t  sample = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_word_t result;

  sample_job_t sample_jobs [$];
  out_word_t   strategy_due [$];

  // Predictor copy of the switch history and debounced positions.
  logic [1:0] last_raw [NUM_SW];
  logic [1:0] settled  [NUM_SW];

  int unsigned words_total    = 0;
  int unsigned words_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;
  int unsigned topo_hits [5];
  int unsigned stall_left     = 0;
  bit          stall_burst    = 1'b0;

  breaker_position_topology_strategy uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the debounce history by one tick and derive the expected
  // positions, topology and transfer strategy for that tick.
  function automatic out_word_t derive_strategy(in_word_t w);
    logic [1:0] raw;
    logic       both_live;
    logic [7:0] lineup;
    out_word_t  r;
    r = '0;
    for (int i = 0; i < NUM_SW; i++) begin
      if (w.contact_on_bits[i] && !w.contact_off_bits[i]) raw = POS_CLOSED;
      else if (!w.contact_on_bits[i] && w.contact_off_bits[i]) raw = POS_OPEN;
      else raw = POS_FAULT;
      // take the new value only when it repeats the previous tick
      if (raw == last_raw[i]) settled[i] = raw;
      last_raw[i] = raw;
    end
    both_live = w.bus1_live && w.bus2_live;
    lineup = {settled[0], settled[1], settled[2], settled[3]};
    if (settled[0] == POS_FAULT || settled[1] == POS_FAULT ||
        settled[2] == POS_FAULT || settled[3] == POS_FAULT)
      r.topology_code = TOPO_ERR;
    else if (settled[1] != settled[3])
      r.topology_code = TOPO_ERR;
    else if (lineup == {POS_CLOSED, POS_CLOSED, POS_OPEN, POS_CLOSED})
      r.topology_code = both_live ? TOPO_SPLIT1 : TOPO_ERR;
    else if (lineup == {POS_OPEN, POS_CLOSED, POS_CLOSED, POS_CLOSED})
      r.topology_code = both_live ? TOPO_SPLIT2 : TOPO_ERR;
    else if (lineup == {POS_CLOSED, POS_OPEN, POS_CLOSED, POS_OPEN})
      r.topology_code = both_live ? TOPO_PAR : TOPO_ERR;
    else if (lineup == {POS_OPEN, POS_OPEN, POS_OPEN, POS_OPEN})
      r.topology_code = TOPO_MAINT;
    else
      r.topology_code = TOPO_ERR;

    // default: lock out, no make, no sync; fault kind zero lands here too
    r.break_step  = BRK_LOCKOUT;
    r.make_step   = MK_NONE;
    r.sync_needed = 1'b0;
    if (r.topology_code == TOPO_PAR) begin
      if (w.fault_kind == FK_FEEDER1) begin
        r.break_step = BRK_TRIP1; r.make_step = MK_CLOSE24; r.sync_needed = 1'b1;
      end else if (w.fault_kind == FK_FEEDER2) begin
        r.break_step = BRK_TRIP3; r.make_step = MK_CLOSE24; r.sync_needed = 1'b1;
      end
    end else if (r.topology_code == TOPO_SPLIT1) begin
      if (w.fault_kind == FK_FEEDER1) begin
        r.break_step = BRK_TRIP1; r.make_step = MK_CLOSE3; r.sync_needed = 1'b1;
      end
    end else if (r.topology_code == TOPO_SPLIT2) begin
      if (w.fault_kind == FK_FEEDER2) begin
        r.break_step = BRK_TRIP3; r.make_step = MK_CLOSE1; r.sync_needed = 1'b1;
      end
    end
    r.pos_sw1 = settled[0];
    r.pos_sw2 = settled[1];
    r.pos_sw3 = settled[2];
    r.pos_sw4 = settled[3];
    topo_hits[r.topology_code]++;
    return r;
  endfunction

  // Queue one sample word; a burst word goes out with no gap in front of it.
  task automatic add_word(input logic [3:0] on, input logic [3:0] off,
                          input logic b1, input logic b2, input logic [1:0] fk,
                          input bit burst);
    sample_job_t job;
    job.w.contact_on_bits  = on;
    job.w.contact_off_bits = off;
    job.w.bus1_live        = b1;
    job.w.bus2_live        = b2;
    job.w.fault_kind       = fk;
    job.gap = burst ? 0 : $urandom_range(0, 17);
    sample_jobs.push_back(job);
    words_total++;
  endtask

  // Sender: hold each word until accepted, then wait out the next word's gap.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        strategy_due.push_back(derive_strategy(sample));
        words_accepted++;
      end
      if (!sample_valid || sample_ready) begin
        if (sample_jobs.size() == 0) begin
          sample_valid <= 1'b0;
        end else if (sample_jobs[0].gap > 0) begin
          sample_jobs[0].gap--;
          sample_valid <= 1'b0;
        end else begin
          sample       <= sample_jobs[0].w;
          sample_valid <= 1'b1;
          void'(sample_jobs.pop_front());
        end
      end
    end
  end

  // Receiver: check each accepted result word against the oldest prediction,
  // then stall a random number of cycles; some stretches never stall.
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (strategy_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result word %0d arrived with no prediction pending", results_seen);
        end else begin
          want = strategy_due.pop_front();
          if (result.pos_sw1 !== want.pos_sw1 || result.pos_sw2 !== want.pos_sw2 ||
              result.pos_sw3 !== want.pos_sw3 || result.pos_sw4 !== want.pos_sw4 ||
              result.topology_code !== want.topology_code ||
              result.break_step !== want.break_step ||
              result.make_step !== want.make_step ||
              result.sync_needed !== want.sync_needed) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display({"word %0d mismatch: expected pos %0d %0d %0d %0d topo %0d ",
                        "brk %0d mk %0d sync %0d, got pos %0d %0d %0d %0d topo %0d ",
                        "brk %0d mk %0d sync %0d"}, results_seen,
                       want.pos_sw1, want.pos_sw2, want.pos_sw3, want.pos_sw4,
                       want.topology_code, want.break_step, want.make_step,
                       want.sync_needed, result.pos_sw1, result.pos_sw2,
                       result.pos_sw3, result.pos_sw4, result.topology_code,
                       result.break_step, result.make_step, result.sync_needed);
          end
        end
        results_seen++;
        if (results_seen % 40 == 0) stall_burst = ($urandom_range(0, 3) == 0);
        stall_left = stall_burst ? 0 : $urandom_range(0, 17);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d predictions still pending",
               cycles, strategy_due.size());
      $display("breaker_position_topology_strategy regression: fail");
      $finish;
    end
  end

  initial begin : stim
    int unsigned seg_len;
    int unsigned pick;
    logic [3:0]  on;
    bit          burst;
    bit          both;
    for (int i = 0; i < NUM_SW; i++) begin
      last_raw[i] = POS_FAULT;
      settled[i]  = POS_OPEN;
    end
    for (int i = 0; i < 5; i++) topo_hits[i] = 0;

    // Directed: each line-up needs two equal ticks before it settles.
    add_word(4'b0000, 4'b1111, 1'b0, 1'b0, FK_OTHER, 1'b0);   // first tick never matches
    add_word(4'b0000, 4'b1111, 1'b0, 1'b0, FK_BUS, 1'b0);
    add_word(4'b1011, 4'b0100, 1'b1, 1'b1, FK_FEEDER1, 1'b0);
    add_word(4'b1011, 4'b0100, 1'b1, 1'b1, FK_FEEDER1, 1'b0);
    add_word(4'b1011, 4'b0100, 1'b1, 1'b1, FK_FEEDER2, 1'b0);  // unmatched feeder
    add_word(4'b1011, 4'b0100, 1'b1, 1'b1, FK_OTHER, 1'b0);    // kind zero: lock out
    add_word(4'b1011, 4'b0100, 1'b1, 1'b0, FK_FEEDER1, 1'b0);  // dead bus: error
    add_word(4'b1110, 4'b0001, 1'b1, 1'b1, FK_FEEDER2, 1'b0);
    add_word(4'b1110, 4'b0001, 1'b1, 1'b1, FK_FEEDER2, 1'b0);
    add_word(4'b1110, 4'b0001, 1'b1, 1'b1, FK_FEEDER1, 1'b0);
    add_word(4'b0101, 4'b1010, 1'b1, 1'b1, FK_FEEDER1, 1'b0);
    add_word(4'b0101, 4'b1010, 1'b1, 1'b1, FK_FEEDER1, 1'b0);
    add_word(4'b0101, 4'b1010, 1'b1, 1'b1, FK_FEEDER2, 1'b0);
    add_word(4'b0101, 4'b1010, 1'b1, 1'b1, FK_BUS, 1'b0);
    add_word(4'b0101, 4'b1010, 1'b1, 1'b1, FK_OTHER, 1'b0);
    add_word(4'b0101, 4'b1010, 1'b0, 1'b1, FK_FEEDER1, 1'b0);
    add_word(4'b1111, 4'b1111, 1'b1, 1'b1, FK_FEEDER1, 1'b0);  // both contacts
    add_word(4'b1111, 4'b1111, 1'b1, 1'b1, FK_FEEDER1, 1'b0);
    add_word(4'b0000, 4'b0000, 1'b1, 1'b1, FK_FEEDER2, 1'b0);  // neither contact
    add_word(4'b0000, 4'b0000, 1'b1, 1'b1, FK_FEEDER2, 1'b0);
    add_word(4'b0011, 4'b1100, 1'b1, 1'b1, FK_FEEDER1, 1'b0);  // sw2 vs sw4 differ
    add_word(4'b0011, 4'b1100, 1'b1, 1'b1, FK_FEEDER1, 1'b0);
    add_word(4'b1111, 4'b0000, 1'b1, 1'b1, FK_FEEDER2, 1'b0);  // all closed
    add_word(4'b1111, 4'b0000, 1'b1, 1'b1, FK_FEEDER2, 1'b0);

    // Random: mostly held line-ups with a stray bouncing tick, the rest noise.
    while (words_total < RANDOM_WORDS + 24) begin
      burst = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 9);
      if (pick < 7) begin
        on = LINEUP_ON[$urandom_range(0, 3) * 4 +: 4];
        seg_len = $urandom_range(2, 6);
        for (int k = 0; k < seg_len; k++) begin
          both = ($urandom_range(0, 4) != 0);
          if ($urandom_range(0, 7) == 0)
            add_word(4'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
                     2'($urandom), burst);
          else
            add_word(on, ~on, both | 1'($urandom_range(0, 1)),
                     both | 1'($urandom_range(0, 1)),
                     2'($urandom_range(0, 3)), burst);
        end
      end else begin
        seg_len = $urandom_range(1, 4);
        for (int k = 0; k < seg_len; k++)
          add_word(4'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
                   2'($urandom), burst);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to go in and every prediction to be matched,
    // then let the clock run on to catch stray result words.
    while (words_accepted < words_total) @(posedge clk);
    while (strategy_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d sample words, %0d result words checked, %0d mismatches",
             words_accepted, results_seen, mismatches);
    $display("topology hits: split1 %0d split2 %0d parallel %0d maint %0d error %0d",
             topo_hits[TOPO_SPLIT1], topo_hits[TOPO_SPLIT2], topo_hits[TOPO_PAR],
             topo_hits[TOPO_MAINT], topo_hits[TOPO_ERR]);
    if (mismatches == 0 && strategy_due.size() == 0) begin
      $display("breaker_position_topology_strategy regression: pass");
    end else begin
      $display("breaker_position_topology_strategy regression: fail");
    end
    $finish;
  end

endmodule

// File: breaker_position_topology_strategy.f
design/bpts_pkg.sv
design/bpts_debounce.sv
design/bpts_strategy.sv
design/breaker_position_topology_strategy.sv
tb/tb_breaker_position_topology_strategy.sv
